// ===== rtl/twhsm_pkg.sv =====
// Shared types, constants and helper functions for the two-wire humidity sensor master.
// No dependencies.
package twhsm_pkg;

  localparam int unsigned ResetClocksDefault = 9;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_SOFTRST = 3'd1,
    FUNC_WRSTAT  = 3'd2,
    FUNC_RDSTAT  = 3'd3,
    FUNC_MEASURE = 3'd4,
    FUNC_RDMEAS  = 3'd5,
    FUNC_RSV6    = 3'd6,
    FUNC_RSV7    = 3'd7
  } func_e;

  typedef enum logic [2:0] {
    SEG_END  = 3'd0,
    SEG_RST  = 3'd1,
    SEG_WCMD = 3'd2,
    SEG_WARG = 3'd3,
    SEG_RACK = 3'd4,
    SEG_RNAK = 3'd5
  } seg_e;

  typedef enum logic [2:0] {
    REG_RESET   = 3'd0,
    REG_STAT_RD = 3'd1,
    REG_STAT_WR = 3'd2,
    REG_TEMP    = 3'd3,
    REG_HUMID   = 3'd4
  } reg_e;

  typedef struct packed {
    logic [2:0] func;
    logic [7:0] arg;
    logic       sda_in;
  } item_t;

  typedef struct packed {
    logic        scl;
    logic        sda_release;
    logic        busy_res;
    logic        done_res;
    logic        no_ack;
    logic        crc_bad;
    logic [15:0] value;
  } result_t;

  typedef struct packed {
    logic [7:0] reset_code;
    logic [7:0] status_read_code;
    logic [7:0] status_write_code;
    logic [7:0] temperature_code;
    logic [7:0] humidity_code;
  } cfg_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) r[i] = v[7-i];
    return r;
  endfunction

  // Bit-serial CRC-8 update over one byte, polynomial 0x31.
  function automatic logic [7:0] crc_byte(input logic [7:0] crc_in, input logic [7:0] d_in);
    logic [7:0] c;
    logic [7:0] d;
    c = crc_in;
    d = d_in;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ d[7]) c = {c[6:0], 1'b1} ^ 8'h30;
      else c = {c[6:0], 1'b0};
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

  function automatic seg_e seg_lookup(input logic [2:0] op, input logic [1:0] seg);
    seg_e s;
    s = SEG_END;
    unique case (op)
      FUNC_SOFTRST, FUNC_MEASURE: begin
        if (seg == 2'd0) s = SEG_RST;
        else if (seg == 2'd1) s = SEG_WCMD;
      end
      FUNC_WRSTAT: begin
        if (seg == 2'd0) s = SEG_RST;
        else if (seg == 2'd1) s = SEG_WCMD;
        else if (seg == 2'd2) s = SEG_WARG;
      end
      FUNC_RDSTAT: begin
        if (seg == 2'd0) s = SEG_RST;
        else if (seg == 2'd1) s = SEG_WCMD;
        else if (seg == 2'd2) s = SEG_RACK;
        else s = SEG_RNAK;
      end
      FUNC_RDMEAS: begin
        if (seg == 2'd0 || seg == 2'd1) s = SEG_RACK;
        else if (seg == 2'd2) s = SEG_RNAK;
      end
      default: s = SEG_END;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/twhsm_front.sv =====
// Front end: input queue interface and a two-entry item queue towards the engine.
// Depends on twhsm_pkg.
module twhsm_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  twhsm_pkg::item_t item_i,
  output logic             q_valid_o,
  output twhsm_pkg::item_t q_item_o,
  input  logic             q_take_i
);
  import twhsm_pkg::*;

  item_t      mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full      = (cnt_q == 2'd2);
  assign do_push   = push && !full;
  assign q_valid_o = (cnt_q != 2'd0);
  assign do_pop    = q_take_i && q_valid_o;
  assign q_item_o  = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop) rd_q <= !rd_q;
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

  // Hold item payloads
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= item_i;
  end
endmodule

// ===== rtl/twhsm_engine.sv =====
// Back end: bus sequencer that performs at most one line step per item and emits a result per item.
// Depends on twhsm_pkg.
module twhsm_engine #(
  parameter int unsigned RESET_CLOCKS = twhsm_pkg::ResetClocksDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  twhsm_pkg::item_t   item_i,
  output logic               in_take_o,
  input  twhsm_pkg::cfg_t    cfg_i,
  output logic               out_valid_o,
  output twhsm_pkg::result_t out_o,
  input  logic               out_take_i
);
  import twhsm_pkg::*;

  localparam int unsigned RstPulses = RESET_CLOCKS * 3;
  localparam int unsigned RstLen    = RstPulses + 8;

  logic [2:0]  op_q, op_d;
  logic [5:0]  ph_q, ph_d;
  logic [1:0]  r3_q, r3_d;
  logic [1:0]  seg_q, seg_d;
  logic [3:0]  bc_q, bc_d;
  logic [7:0]  sh_q, sh_d, crc_q, crc_d, st_q, st_d, arg_q, arg_d;
  logic [15:0] val_q, val_d;
  logic [1:0]  err_q, err_d;
  logic        scl_q, scl_d, sda_q, sda_d;
  logic        ov_q;
  result_t     res_q, res_d;
  logic        step, done;
  seg_e        kind, nxt;
  logic [7:0]  cmd, b;
  logic [5:0]  len;
  logic [2:0]  sq;

  // Accept an item when the result register is free or being drained
  assign in_take_o   = !ov_q || out_take_i;
  assign step        = in_valid_i && in_take_o;
  assign out_valid_o = ov_q;
  assign out_o       = res_q;

  always_comb begin
    unique case (op_q)
      FUNC_SOFTRST: cmd = cfg_i.reset_code;
      FUNC_WRSTAT:  cmd = cfg_i.status_write_code;
      FUNC_RDSTAT:  cmd = cfg_i.status_read_code;
      default:      cmd = arg_q[0] ? cfg_i.humidity_code : cfg_i.temperature_code;
    endcase
  end

  assign kind = seg_lookup(op_q, seg_q);
  assign b    = sh_q;
  assign sq   = 3'(ph_q - 6'(RstPulses));

  always_comb begin
    if (kind == SEG_RST) len = 6'(RstLen);
    else if (kind == SEG_WCMD || kind == SEG_WARG) len = 6'd27;
    else len = 6'd21;
  end

  // Step the sequencer
  always_comb begin
    op_d = op_q; ph_d = ph_q; r3_d = r3_q; seg_d = seg_q; bc_d = bc_q;
    sh_d = sh_q; crc_d = crc_q; st_d = st_q; arg_d = arg_q; val_d = val_q;
    err_d = err_q; scl_d = scl_q; sda_d = sda_q; done = 1'b0; nxt = SEG_END;
    if (op_q == FUNC_TICK) begin
      if (item_i.func >= FUNC_SOFTRST && item_i.func <= FUNC_RDMEAS) begin
        op_d = item_i.func; arg_d = item_i.arg; seg_d = '0; ph_d = '0;
        r3_d = '0; bc_d = '0; err_d = '0;
        crc_d = reverse8({4'h0, st_q[3:0]});
        if (item_i.func == FUNC_RDSTAT)
          crc_d = crc_byte(reverse8({4'h0, st_q[3:0]}), cfg_i.status_read_code);
        else if (item_i.func == FUNC_RDMEAS)
          crc_d = crc_byte(reverse8({4'h0, st_q[3:0]}),
                           item_i.arg[0] ? cfg_i.humidity_code : cfg_i.temperature_code);
      end
    end else if (item_i.func == FUNC_TICK) begin
      if (kind == SEG_RST) begin
        if (ph_q < 6'(RstPulses)) begin
          if (r3_q == 2'd0) sda_d = 1'b1;
          else scl_d = (r3_q == 2'd1);
        end else begin
          case (sq)
            3'd0: scl_d = 1'b0;
            3'd1: sda_d = 1'b1;
            3'd2: scl_d = 1'b1;
            3'd3: sda_d = 1'b0;
            3'd4: scl_d = 1'b0;
            3'd5: scl_d = 1'b1;
            3'd6: sda_d = 1'b1;
            default: scl_d = 1'b0;
          endcase
        end
      end else if (kind == SEG_WCMD || kind == SEG_WARG) begin
        if (ph_q < 6'd24) begin
          if (r3_q == 2'd0) sda_d = sh_q[7];
          else if (r3_q == 2'd1) scl_d = 1'b1;
          else begin
            scl_d = 1'b0; sh_d = {sh_q[6:0], 1'b0}; bc_d = bc_q + 4'd1;
          end
        end else if (ph_q == 6'd24) sda_d = 1'b1;
        else if (ph_q == 6'd25) scl_d = 1'b1;
        else begin
          if (item_i.sda_in) err_d[0] = 1'b1;
          scl_d = 1'b0;
        end
      end else begin
        if (ph_q == 6'd0) begin
          sda_d = 1'b1; sh_d = '0; bc_d = '0;
        end else if (ph_q <= 6'd16) begin
          if (ph_q[0]) scl_d = 1'b1;
          else begin
            sh_d = {sh_q[6:0], item_i.sda_in}; bc_d = bc_q + 4'd1; scl_d = 1'b0;
          end
        end else if (ph_q == 6'd17) sda_d = (kind == SEG_RNAK);
        else if (ph_q == 6'd18) scl_d = 1'b1;
        else if (ph_q == 6'd19) scl_d = 1'b0;
        else begin
          sda_d = 1'b1;
          if (kind == SEG_RNAK) begin
            if (reverse8(crc_q) != b) err_d[1] = 1'b1;
          end else begin
            crc_d = crc_byte(crc_q, b);
            if (op_q == FUNC_RDSTAT) val_d = {8'h00, b};
            else if (seg_q == 2'd0) val_d = {b, 8'h00};
            else val_d = {val_q[15:8], b};
          end
        end
      end
      ph_d = ph_q + 6'd1;
      r3_d = (r3_q == 2'd2) ? 2'd0 : r3_q + 2'd1;
      if (ph_q + 6'd1 >= len) begin
        ph_d = '0; r3_d = '0; bc_d = '0; seg_d = seg_q + 2'd1;
        nxt = (seg_q == 2'd3) ? SEG_END : seg_lookup(op_q, seg_q + 2'd1);
        if (nxt == SEG_WCMD) sh_d = cmd;
        else if (nxt == SEG_WARG) sh_d = arg_q;
        if (nxt == SEG_END) begin
          done = 1'b1;
          if (op_q == FUNC_SOFTRST && !err_d[0]) st_d = '0;
          else if (op_q == FUNC_WRSTAT && !err_d[0]) st_d = arg_q;
          else if (op_q == FUNC_RDSTAT && err_d == 2'b00) st_d = val_d[7:0];
          op_d = FUNC_TICK; seg_d = '0;
        end
      end
    end
    res_d.scl = scl_d; res_d.sda_release = sda_d; res_d.busy_res = (op_d != FUNC_TICK);
    res_d.done_res = done; res_d.no_ack = err_d[0]; res_d.crc_bad = err_d[1];
    res_d.value = val_d;
  end

  // Hold sequencer state and the result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q <= FUNC_TICK; ph_q <= '0; r3_q <= '0; seg_q <= '0; bc_q <= '0;
      sh_q <= '0; crc_q <= '0; st_q <= '0; arg_q <= '0; val_q <= '0;
      err_q <= '0; scl_q <= 1'b0; sda_q <= 1'b1; ov_q <= 1'b0;
    end else begin
      if (step) begin
        op_q <= op_d; ph_q <= ph_d; r3_q <= r3_d; seg_q <= seg_d; bc_q <= bc_d;
        sh_q <= sh_d; crc_q <= crc_d; st_q <= st_d; arg_q <= arg_d; val_q <= val_d;
        err_q <= err_d; scl_q <= scl_d; sda_q <= sda_d;
      end
      if (step) ov_q <= 1'b1;
      else if (out_take_i) ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) res_q <= res_d;
  end
endmodule

// ===== rtl/twhsm_cfg.sv =====
// Configuration register file holding the five command bytes.
// Depends on twhsm_pkg.
module twhsm_cfg (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [2:0]      cfg_index_i,
  input  logic [7:0]      cfg_data_i,
  output twhsm_pkg::cfg_t cfg_o
);
  import twhsm_pkg::*;

  cfg_t cfg_q;
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // Write the addressed command byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{8'd30, 8'd7, 8'd6, 8'd3, 8'd5};
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_RESET:   cfg_q.reset_code        <= cfg_data_i;
        REG_STAT_RD: cfg_q.status_read_code  <= cfg_data_i;
        REG_STAT_WR: cfg_q.status_write_code <= cfg_data_i;
        REG_TEMP:    cfg_q.temperature_code  <= cfg_data_i;
        REG_HUMID:   cfg_q.humidity_code     <= cfg_data_i;
        default: ;
      endcase
    end
  end
endmodule

// ===== rtl/two_wire_humidity_sensor_master_unit.sv =====
// Top level of the two-wire humidity sensor bus master.
// Depends on twhsm_pkg, twhsm_front, twhsm_cfg and twhsm_engine.
//
// One item in, one result out: a new item may be pushed every cycle while the
// queue is not full; a two-entry input queue and a result register let either
// side stall independently. A pushed item is registered in the input queue,
// and its result then in the result register. Configuration is to be written
// only while idle; the block itself does not enforce this.
module two_wire_humidity_sensor_master_unit #(
  parameter int unsigned RESET_CLOCKS = twhsm_pkg::ResetClocksDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  twhsm_pkg::item_t   item_i,
  output logic               empty,
  input  logic               pop,
  output twhsm_pkg::result_t result_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [7:0]         cfg_data_i
);
  import twhsm_pkg::*;

  logic  q_valid, q_take, o_valid;
  item_t q_item;
  cfg_t  cfg;

  twhsm_front u_front (
    .clk_i, .rst_ni, .push, .full, .item_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_take_i(q_take)
  );

  twhsm_cfg u_cfg (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i, .cfg_o(cfg)
  );

  twhsm_engine #(.RESET_CLOCKS(RESET_CLOCKS)) u_engine (
    .clk_i, .rst_ni, .in_valid_i(q_valid), .item_i(q_item), .in_take_o(q_take),
    .cfg_i(cfg), .out_valid_o(o_valid), .out_o(result_o), .out_take_i(pop)
  );

  assign empty = !o_valid;

  // A finishing beat is never busy
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && result_o.done_res) |-> !result_o.busy_res) else $error("done while busy");

  // An unpopped result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(result_o)) else $error("result changed while waiting");

  // A popped result with nothing queued leaves the output empty
  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !q_valid) |=> empty) else $error("spurious result");
endmodule
